### rtl/bgi_pkg.sv
// Shared types and constants of the bilinear grid interpolator.
`timescale 1ns / 1ps
`default_nettype none

package bgi_pkg;

  // Default sizes
  localparam int MaxXPointsDef = 64;
  localparam int MaxYPointsDef = 64;
  localparam int FracBitsDef   = 16;

  // Operation codes of an input beat
  typedef enum logic [1:0] {
    OP_LOAD_X = 2'd0,
    OP_LOAD_Y = 2'd1,
    OP_LOAD_F = 2'd2,
    OP_QUERY  = 2'd3
  } op_e;

  // Result status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;

  // Interpolation pass selects
  localparam logic [1:0] LSEL_F1  = 2'd0;
  localparam logic [1:0] LSEL_F2  = 2'd1;
  localparam logic [1:0] LSEL_RES = 2'd2;

  // Configuration register indexes
  localparam logic CFG_POINTS_X = 1'b0;
  localparam logic CFG_POINTS_Y = 1'b1;

  typedef struct packed {
    logic [1:0]         op;
    logic [5:0]         index_x;
    logic [5:0]         index_y;
    logic signed [31:0] load_value;
    logic signed [31:0] query_x;
    logic signed [31:0] query_y;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic [1:0]         status;
  } out_beat_t;

  // Controller to datapath commands
  typedef struct packed {
    logic       accept;
    logic       scan_x_rd;
    logic       scan_y_rd;
    logic       fin_x;
    logic       fin_y;
    logic       crd_rd;
    logic       f_rd;
    logic       f_direct;
    logic       lerp_init;
    logic       div_step;
    logic       lerp_sat;
    logic       lerp_mul;
    logic       lerp_fin;
    logic [1:0] lerp_sel;
    logic       res_from_f1;
    logic       out_load;
    logic       zero;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic dx_zero;
    logic dy_zero;
  } stat_t;

endpackage

`default_nettype wire

### rtl/bilinear_grid_interpolator_unit.sv
// Top level of the bilinear grid interpolator.
`timescale 1ns / 1ps
`default_nettype none

// Bilinear interpolation on a rectilinear grid in signed fixed point (Q16.16 at the
// default FRAC_BITS). Load beats (x coordinate, y coordinate, table value) give no
// result. A query beat scans the x and y coordinate memories one entry per cycle,
// fetches the bracketing coordinates and four table values, then runs up to three
// interpolation passes on one shared unit whose bit-serial divider sets the pace.
// Fewer passes run when an axis has one point. The input is held off while a query
// runs; a finished result waits in the output register while the next beat is taken.
module bilinear_grid_interpolator_unit #(
  parameter int MAX_X_POINTS = bgi_pkg::MaxXPointsDef,
  parameter int MAX_Y_POINTS = bgi_pkg::MaxYPointsDef,
  parameter int FRAC_BITS    = bgi_pkg::FracBitsDef
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  input  bgi_pkg::in_beat_t   in_data_i,
  output logic                out_valid_o,
  input  wire                 out_ready_i,
  output bgi_pkg::out_beat_t  out_data_o,
  input  wire                 cfg_we_i,
  input  wire                 cfg_idx_i,
  input  wire [6:0]           cfg_data_i
);

  localparam int NXW  = $clog2(MAX_X_POINTS + 1);
  localparam int NYW  = $clog2(MAX_Y_POINTS + 1);
  localparam int NUMW = 33 + FRAC_BITS;
  localparam int CW   = $clog2(MAX_X_POINTS + MAX_Y_POINTS + NUMW + 2);

  bgi_pkg::cmd_t  cmd;
  bgi_pkg::stat_t stat;
  logic [CW-1:0]  step_idx;
  logic [NXW-1:0] nx;
  logic [NYW-1:0] ny;

  bgi_ctrl #(
    .MAX_X_POINTS(MAX_X_POINTS),
    .MAX_Y_POINTS(MAX_Y_POINTS),
    .FRAC_BITS   (FRAC_BITS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_op_i    (in_data_i.op),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cmd_o      (cmd),
    .stat_i     (stat),
    .step_idx_o (step_idx),
    .nx_o       (nx),
    .ny_o       (ny)
  );

  bgi_datapath #(
    .MAX_X_POINTS(MAX_X_POINTS),
    .MAX_Y_POINTS(MAX_Y_POINTS),
    .FRAC_BITS   (FRAC_BITS)
  ) u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .stat_o    (stat),
    .step_idx_i(step_idx),
    .nx_i      (nx),
    .ny_i      (ny),
    .in_data_i (in_data_i),
    .out_data_o(out_data_o)
  );

endmodule

`default_nettype wire

### rtl/bgi_datapath.sv
// Datapath: grid memories, bracket scan, coordinate and table fetch, shared lerp unit.
`timescale 1ns / 1ps
`default_nettype none

module bgi_datapath #(
  parameter int MAX_X_POINTS = bgi_pkg::MaxXPointsDef,
  parameter int MAX_Y_POINTS = bgi_pkg::MaxYPointsDef,
  parameter int FRAC_BITS    = bgi_pkg::FracBitsDef,
  localparam int NXW  = $clog2(MAX_X_POINTS + 1),
  localparam int NYW  = $clog2(MAX_Y_POINTS + 1),
  localparam int NUMW = 33 + FRAC_BITS,
  localparam int CW   = $clog2(MAX_X_POINTS + MAX_Y_POINTS + NUMW + 2)
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  bgi_pkg::cmd_t       cmd_i,
  output bgi_pkg::stat_t      stat_o,
  input  wire [CW-1:0]        step_idx_i,
  input  wire [NXW-1:0]       nx_i,
  input  wire [NYW-1:0]       ny_i,
  input  bgi_pkg::in_beat_t   in_data_i,
  output bgi_pkg::out_beat_t  out_data_o
);

  localparam int XAW = $clog2(MAX_X_POINTS);
  localparam int YAW = $clog2(MAX_Y_POINTS);
  localparam int FAW = $clog2(MAX_X_POINTS * MAX_Y_POINTS);
  localparam int BW  = (XAW > YAW) ? XAW : YAW;
  localparam int DW  = 34;
  localparam logic signed [64:0] TLim = 65'sd1099511627776;

  // Bracket from scan results: returns {hi, lo}
  function automatic logic [2*BW-1:0] bracket(input logic ge, input logic [BW-1:0] fg,
                                              input logic lt, input logic [BW-1:0] ll,
                                              input logic [BW:0] n);
    logic [BW:0] n1, lo, hi, ll1;
    n1  = n - (BW+1)'(1);
    ll1 = {1'b0, ll} + (BW+1)'(1);
    lo  = ge ? ((fg == '0) ? '0 : ({1'b0, fg} - (BW+1)'(1))) : n1;
    hi  = lt ? ((ll1 > n1) ? n1 : ll1) : '0;
    if (n < (BW+1)'(2)) begin
      lo = '0;
      hi = '0;
    end else if (hi == lo) begin
      if (hi == '0) hi = (BW+1)'(1);
      else if (hi == n1) lo = lo - (BW+1)'(1);
    end
    return {hi[BW-1:0], lo[BW-1:0]};
  endfunction

  // Memories
  logic signed [31:0] x_mem [MAX_X_POINTS];
  logic signed [31:0] y_mem [MAX_Y_POINTS];
  logic signed [31:0] f_mem [MAX_X_POINTS*MAX_Y_POINTS];
  logic signed [31:0] x_rd_q, y_rd_q, f_rd_q;

  logic [BW-1:0] xl_q, xh_q, yl_q, yh_q;
  logic [BW-1:0] fg_q, ll_q, scan_idx_q;
  logic          ge_q, lt_q, scan_vld_q, scan_ax_q;
  logic          crd_vld_q, crd_sel_q, f_vld_q;
  logic [1:0]    f_sel_q;
  logic signed [31:0] qx_q, qy_q, cxl_q, cxh_q, cyl_q, cyh_q;
  logic signed [31:0] fll_q, fhl_q, flh_q, fhh_q, f1_q, f2_q, res_q;

  // Load decode
  logic x_we, y_we, f_we, x_re, y_re;
  logic [XAW-1:0] x_raddr;
  logic [YAW-1:0] y_raddr;
  logic [FAW-1:0] f_waddr, f_raddr;
  logic [BW-1:0]  fx_sel, fy_sel;

  assign x_we = cmd_i.accept && (in_data_i.op == bgi_pkg::OP_LOAD_X) &&
                (32'(in_data_i.index_x) < MAX_X_POINTS);
  assign y_we = cmd_i.accept && (in_data_i.op == bgi_pkg::OP_LOAD_Y) &&
                (32'(in_data_i.index_y) < MAX_Y_POINTS);
  assign f_we = cmd_i.accept && (in_data_i.op == bgi_pkg::OP_LOAD_F) &&
                (32'(in_data_i.index_x) < MAX_X_POINTS) &&
                (32'(in_data_i.index_y) < MAX_Y_POINTS);
  assign f_waddr = FAW'(32'(in_data_i.index_x) * MAX_Y_POINTS + 32'(in_data_i.index_y));

  // Read addresses: scan index or bracket ends
  assign x_re    = cmd_i.scan_x_rd || cmd_i.crd_rd;
  assign y_re    = cmd_i.scan_y_rd || cmd_i.crd_rd;
  assign x_raddr = cmd_i.scan_x_rd ? XAW'(step_idx_i) :
                   (step_idx_i[0] ? XAW'(xh_q) : XAW'(xl_q));
  assign y_raddr = cmd_i.scan_y_rd ? YAW'(step_idx_i) :
                   (step_idx_i[0] ? YAW'(yh_q) : YAW'(yl_q));
  assign fx_sel  = step_idx_i[0] ? xh_q : xl_q;
  assign fy_sel  = step_idx_i[1] ? yh_q : yl_q;
  assign f_raddr = FAW'(32'(fx_sel) * MAX_Y_POINTS + 32'(fy_sel));

  always_ff @(posedge clk_i) begin
    if (x_we) x_mem[XAW'(in_data_i.index_x)] <= in_data_i.load_value;
    if (x_re) x_rd_q <= x_mem[x_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (y_we) y_mem[YAW'(in_data_i.index_y)] <= in_data_i.load_value;
    if (y_re) y_rd_q <= y_mem[y_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (f_we) f_mem[f_waddr] <= in_data_i.load_value;
    if (cmd_i.f_rd) f_rd_q <= f_mem[f_raddr];
  end

  // Read tracking, registered alongside the memory read data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_vld_q <= 1'b0;
      scan_ax_q  <= 1'b0;
      scan_idx_q <= '0;
      crd_vld_q  <= 1'b0;
      crd_sel_q  <= 1'b0;
      f_vld_q    <= 1'b0;
      f_sel_q    <= '0;
    end else begin
      scan_vld_q <= cmd_i.scan_x_rd || cmd_i.scan_y_rd;
      scan_ax_q  <= cmd_i.scan_y_rd;
      scan_idx_q <= BW'(step_idx_i);
      crd_vld_q  <= cmd_i.crd_rd;
      crd_sel_q  <= step_idx_i[0];
      f_vld_q    <= cmd_i.f_rd;
      f_sel_q    <= step_idx_i[1:0];
    end
  end

  // Bracket scan: first entry not below the point, last entry below it
  logic               scan_lt;
  logic [2*BW-1:0]    brk_x, brk_y;

  assign scan_lt = scan_ax_q ? (y_rd_q < qy_q) : (x_rd_q < qx_q);
  assign brk_x   = bracket(ge_q, fg_q, lt_q, ll_q, (BW+1)'(nx_i));
  assign brk_y   = bracket(ge_q, fg_q, lt_q, ll_q, (BW+1)'(ny_i));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ge_q <= 1'b0;
      lt_q <= 1'b0;
    end else if (cmd_i.accept || cmd_i.fin_x || cmd_i.fin_y) begin
      ge_q <= 1'b0;
      lt_q <= 1'b0;
    end else if (scan_vld_q) begin
      if (!scan_lt && !ge_q) ge_q <= 1'b1;
      if (scan_lt) lt_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (scan_vld_q) begin
      if (!scan_lt && !ge_q) fg_q <= scan_idx_q;
      if (scan_lt) ll_q <= scan_idx_q;
    end
    if (cmd_i.accept) begin
      qx_q <= in_data_i.query_x;
      qy_q <= in_data_i.query_y;
    end
    if (cmd_i.fin_x) {xh_q, xl_q} <= brk_x;
    if (cmd_i.fin_y) {yh_q, yl_q} <= brk_y;
    if (crd_vld_q) begin
      if (crd_sel_q) begin
        cxh_q <= x_rd_q;
        cyh_q <= y_rd_q;
      end else begin
        cxl_q <= x_rd_q;
        cyl_q <= y_rd_q;
      end
    end
    if (f_vld_q) begin
      case (f_sel_q)
        2'd0:    fll_q <= f_rd_q;
        2'd1:    fhl_q <= f_rd_q;
        2'd2:    flh_q <= f_rd_q;
        default: fhh_q <= f_rd_q;
      endcase
    end
  end

  // Spacings and offsets
  logic signed [32:0] dx, dy, ox, oy;
  assign dx = 33'(cxh_q) - 33'(cxl_q);
  assign dy = 33'(cyh_q) - 33'(cyl_q);
  assign ox = 33'(qx_q) - 33'(cxl_q);
  assign oy = 33'(qy_q) - 33'(cyl_q);
  assign stat_o.dx_zero = (dx == '0);
  assign stat_o.dy_zero = (dy == '0);

  // Lerp operand select
  logic signed [31:0] fl, fh;
  logic signed [32:0] dc, off, diff;
  logic [32:0]        diff_mag, dc_mag;

  always_comb begin
    case (cmd_i.lerp_sel)
      bgi_pkg::LSEL_F1: begin
        fl = fll_q; fh = fhl_q; dc = dx; off = ox;
      end
      bgi_pkg::LSEL_F2: begin
        fl = flh_q; fh = fhh_q; dc = dx; off = ox;
      end
      default: begin
        fl = f1_q; fh = f2_q; dc = dy; off = oy;
      end
    endcase
  end

  assign diff     = 33'(fh) - 33'(fl);
  assign diff_mag = diff[32] ? 33'(-diff) : 33'(diff);
  assign dc_mag   = dc[32] ? 33'(-dc) : 33'(dc);

  // Restoring divider, one quotient bit per step
  logic [DW-1:0]   rem_q, rem_sh;
  logic [NUMW-1:0] quo_q;
  logic [32:0]     dmag_q;
  logic            neg_q, sat_q;
  logic signed [31:0] slope_q;
  logic signed [64:0] prod_q, tsh;
  logic signed [41:0] tcl;
  logic signed [42:0] vsum;
  logic signed [31:0] vsat;
  logic               vsat_ovf;

  assign rem_sh = {rem_q[DW-2:0], quo_q[NUMW-1]};

  // Value = f_low + floor(slope * offset), clamped then saturated
  assign tsh = prod_q >>> FRAC_BITS;
  always_comb begin
    if (tsh > TLim) tcl = 42'(TLim);
    else if (tsh < -TLim) tcl = 42'(-TLim);
    else tcl = 42'(tsh);
    vsum = 43'(tcl) + 43'(fl);
    vsat_ovf = 1'b0;
    if (vsum > 43'sd2147483647) begin
      vsat = 32'sh7fffffff; vsat_ovf = 1'b1;
    end else if (vsum < -43'sd2147483648) begin
      vsat = 32'sh80000000; vsat_ovf = 1'b1;
    end else begin
      vsat = 32'(vsum);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.lerp_init) begin
      rem_q  <= '0;
      quo_q  <= NUMW'(diff_mag) << FRAC_BITS;
      dmag_q <= dc_mag;
      neg_q  <= diff[32] ^ dc[32];
    end
    if (cmd_i.div_step) begin
      if (rem_sh >= DW'(dmag_q)) begin
        rem_q <= rem_sh - DW'(dmag_q);
        quo_q <= {quo_q[NUMW-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh;
        quo_q <= {quo_q[NUMW-2:0], 1'b0};
      end
    end
    if (cmd_i.lerp_sat) begin
      if (!neg_q) slope_q <= (quo_q > NUMW'(32'h7fffffff)) ? 32'sh7fffffff : quo_q[31:0];
      else slope_q <= (quo_q > NUMW'(33'h080000000)) ? 32'sh80000000 : -quo_q[31:0];
    end
    if (cmd_i.lerp_mul) prod_q <= 65'(slope_q) * 65'(off);
    if (cmd_i.lerp_fin) begin
      case (cmd_i.lerp_sel)
        bgi_pkg::LSEL_F1: f1_q <= vsat;
        bgi_pkg::LSEL_F2: f2_q <= vsat;
        default:          res_q <= vsat;
      endcase
    end
    if (cmd_i.f_direct) begin
      f1_q <= fll_q;
      f2_q <= flh_q;
    end
    if (cmd_i.res_from_f1) res_q <= f1_q;
    if (cmd_i.out_load) begin
      out_data_o.result_value <= cmd_i.zero ? 32'sd0 : res_q;
      out_data_o.status <= cmd_i.zero ? bgi_pkg::ST_ZERO :
                           (sat_q ? bgi_pkg::ST_SAT : bgi_pkg::ST_OK);
    end
  end

  // Sticky saturation flag per query
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sat_q <= 1'b0;
    end else if (cmd_i.accept) begin
      sat_q <= 1'b0;
    end else begin
      if (cmd_i.lerp_sat && !neg_q && (quo_q > NUMW'(32'h7fffffff))) sat_q <= 1'b1;
      if (cmd_i.lerp_sat && neg_q && (quo_q > NUMW'(33'h080000000))) sat_q <= 1'b1;
      if (cmd_i.lerp_fin && vsat_ovf) sat_q <= 1'b1;
    end
  end

endmodule

`default_nettype wire

### rtl/bgi_ctrl.sv
// Controller: configuration registers, query sequencer and output valid.
`timescale 1ns / 1ps
`default_nettype none

module bgi_ctrl #(
  parameter int MAX_X_POINTS = bgi_pkg::MaxXPointsDef,
  parameter int MAX_Y_POINTS = bgi_pkg::MaxYPointsDef,
  parameter int FRAC_BITS    = bgi_pkg::FracBitsDef,
  localparam int NXW  = $clog2(MAX_X_POINTS + 1),
  localparam int NYW  = $clog2(MAX_Y_POINTS + 1),
  localparam int NUMW = 33 + FRAC_BITS,
  localparam int CW   = $clog2(MAX_X_POINTS + MAX_Y_POINTS + NUMW + 2)
) (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             in_valid_i,
  output logic            in_ready_o,
  input  wire [1:0]       in_op_i,
  output logic            out_valid_o,
  input  wire             out_ready_i,
  input  wire             cfg_we_i,
  input  wire             cfg_idx_i,
  input  wire [6:0]       cfg_data_i,
  output bgi_pkg::cmd_t   cmd_o,
  input  bgi_pkg::stat_t  stat_i,
  output logic [CW-1:0]   step_idx_o,
  output logic [NXW-1:0]  nx_o,
  output logic [NYW-1:0]  ny_o
);

  typedef enum logic [4:0] {
    S_IDLE, S_XSCAN, S_XWAIT, S_XFIN, S_YSCAN, S_YWAIT, S_YFIN,
    S_CRD, S_CWAIT, S_FRD, S_FWAIT, S_DECIDE,
    S_LINIT, S_LDIV, S_LSAT, S_LMUL, S_LFIN, S_YSTAGE, S_OUT
  } state_e;

  state_e      state_q;
  logic [CW-1:0] cnt_q;
  logic [1:0]  sel_q;
  logic        zero_q, out_valid_q;
  logic [6:0]  points_x_q, points_y_q;
  logic [31:0] px, py;
  logic        accept, query, nx_gt1, ny_gt1, out_free;

  // Points in use: zero reads as one, clamped to the axis size
  assign px = 32'(points_x_q);
  assign py = 32'(points_y_q);
  assign nx_o = (px == 32'd0) ? NXW'(1) : ((px > MAX_X_POINTS) ? NXW'(MAX_X_POINTS) : NXW'(px));
  assign ny_o = (py == 32'd0) ? NYW'(1) : ((py > MAX_Y_POINTS) ? NYW'(MAX_Y_POINTS) : NYW'(py));
  assign nx_gt1 = nx_o > NXW'(1);
  assign ny_gt1 = ny_o > NYW'(1);

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign accept      = in_valid_i && in_ready_o;
  assign query       = (in_op_i == bgi_pkg::OP_QUERY);
  assign out_free    = !out_valid_q || out_ready_i;
  assign step_idx_o  = cnt_q;

  // Command decode
  always_comb begin
    cmd_o             = '0;
    cmd_o.accept      = accept;
    cmd_o.scan_x_rd   = (state_q == S_XSCAN);
    cmd_o.scan_y_rd   = (state_q == S_YSCAN);
    cmd_o.fin_x       = (state_q == S_XFIN);
    cmd_o.fin_y       = (state_q == S_YFIN);
    cmd_o.crd_rd      = (state_q == S_CRD);
    cmd_o.f_rd        = (state_q == S_FRD);
    cmd_o.f_direct    = (state_q == S_DECIDE) && !nx_gt1;
    cmd_o.lerp_init   = (state_q == S_LINIT);
    cmd_o.div_step    = (state_q == S_LDIV);
    cmd_o.lerp_sat    = (state_q == S_LSAT);
    cmd_o.lerp_mul    = (state_q == S_LMUL);
    cmd_o.lerp_fin    = (state_q == S_LFIN);
    cmd_o.lerp_sel    = sel_q;
    cmd_o.res_from_f1 = (state_q == S_YSTAGE) && !ny_gt1;
    cmd_o.out_load    = (state_q == S_OUT) && out_free;
    cmd_o.zero        = zero_q;
  end

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      sel_q       <= bgi_pkg::LSEL_F1;
      zero_q      <= 1'b0;
      out_valid_q <= 1'b0;
      points_x_q  <= 7'd1;
      points_y_q  <= 7'd1;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == bgi_pkg::CFG_POINTS_X) points_x_q <= cfg_data_i;
        else points_y_q <= cfg_data_i;
      end
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (accept && query) begin
            cnt_q   <= '0;
            zero_q  <= 1'b0;
            state_q <= nx_gt1 ? S_XSCAN : S_XFIN;
          end
        end
        S_XSCAN: begin
          cnt_q <= cnt_q + CW'(1);
          if (cnt_q == CW'(nx_o) - CW'(1)) state_q <= S_XWAIT;
        end
        S_XWAIT: state_q <= S_XFIN;
        S_XFIN: begin
          cnt_q   <= '0;
          state_q <= ny_gt1 ? S_YSCAN : S_YFIN;
        end
        S_YSCAN: begin
          cnt_q <= cnt_q + CW'(1);
          if (cnt_q == CW'(ny_o) - CW'(1)) state_q <= S_YWAIT;
        end
        S_YWAIT: state_q <= S_YFIN;
        S_YFIN: begin
          cnt_q   <= '0;
          state_q <= S_CRD;
        end
        S_CRD: begin
          cnt_q <= cnt_q + CW'(1);
          if (cnt_q == CW'(1)) state_q <= S_CWAIT;
        end
        S_CWAIT: begin
          cnt_q   <= '0;
          state_q <= S_FRD;
        end
        S_FRD: begin
          cnt_q <= cnt_q + CW'(1);
          if (cnt_q == CW'(3)) state_q <= S_FWAIT;
        end
        S_FWAIT: state_q <= S_DECIDE;
        S_DECIDE: begin
          if (!nx_gt1) begin
            state_q <= S_YSTAGE;
          end else if (stat_i.dx_zero) begin
            zero_q  <= 1'b1;
            state_q <= S_OUT;
          end else begin
            sel_q   <= bgi_pkg::LSEL_F1;
            state_q <= S_LINIT;
          end
        end
        S_LINIT: begin
          cnt_q   <= '0;
          state_q <= S_LDIV;
        end
        S_LDIV: begin
          cnt_q <= cnt_q + CW'(1);
          if (cnt_q == CW'(NUMW - 1)) state_q <= S_LSAT;
        end
        S_LSAT: state_q <= S_LMUL;
        S_LMUL: state_q <= S_LFIN;
        S_LFIN: begin
          case (sel_q)
            bgi_pkg::LSEL_F1: begin
              if (ny_gt1) begin
                sel_q   <= bgi_pkg::LSEL_F2;
                state_q <= S_LINIT;
              end else begin
                state_q <= S_YSTAGE;
              end
            end
            bgi_pkg::LSEL_F2: state_q <= S_YSTAGE;
            default:          state_q <= S_OUT;
          endcase
        end
        S_YSTAGE: begin
          if (!ny_gt1) begin
            state_q <= S_OUT;
          end else if (stat_i.dy_zero) begin
            zero_q  <= 1'b1;
            state_q <= S_OUT;
          end else begin
            sel_q   <= bgi_pkg::LSEL_RES;
            state_q <= S_LINIT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // A load beat never produces a result beat
  a_load_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !query && !out_valid_q) |=> !out_valid_q)
    else $error("result raised after a load beat");

  // Result is only loaded into a free output register
  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || out_ready_i))
    else $error("output register overwritten");

  // Divider runs a bounded number of steps
  a_div_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LDIV) |-> (cnt_q < CW'(NUMW)))
    else $error("divider step count overrun");

  // A query blocks the input until its result is done
  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && query) |=> !in_ready_o)
    else $error("input taken during a query");

endmodule

`default_nettype wire

### tb/bilinear_grid_interpolator_unit_tb.sv
// Self-checking testbench of the bilinear grid interpolator: loads grids, queries points.
`timescale 1ns / 1ps
`default_nettype none

module bilinear_grid_interpolator_unit_tb;

  localparam int NumItems = 1400;
  localparam int SettleCycles = 400;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  bgi_pkg::in_beat_t  in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  bgi_pkg::out_beat_t out_data;
  logic               cfg_we = 1'b0;
  logic               cfg_idx = 1'b0;
  logic [6:0]         cfg_data = '0;

  bilinear_grid_interpolator_unit dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  // Shadow copy of the grid and point counts
  int         grid_x[64];
  int         grid_y[64];
  int         grid_f[4096];
  logic [6:0] cnt_x = 7'd1;
  logic [6:0] cnt_y = 7'd1;

  bgi_pkg::out_beat_t pending_results[$];
  int         n_beats = 0;
  int         n_queries = 0;
  int         n_checked = 0;
  int         n_zero = 0;
  int         n_sat = 0;
  int         n_errors = 0;
  int         burst_left = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- prediction
  function automatic int clamp32(longint v, inout bit sat);
    if (v > 64'sd2147483647) begin
      sat = 1'b1;
      return 32'h7FFF_FFFF;
    end
    if (v < -64'sd2147483648) begin
      sat = 1'b1;
      return 32'h8000_0000;
    end
    return int'(v);
  endfunction

  function automatic int lerp_q(int f_lo, int f_hi, longint dc, longint off, inout bit sat);
    longint num, t;
    int     slope;
    num   = (longint'(f_hi) - longint'(f_lo)) * 64'sd65536;
    slope = clamp32(num / dc, sat);
    t     = (longint'(slope) * off) >>> 16;  // arithmetic shift floors
    if (t > (64'sd1 <<< 40)) t = 64'sd1 <<< 40;
    if (t < -(64'sd1 <<< 40)) t = -(64'sd1 <<< 40);
    return clamp32(longint'(f_lo) + t, sat);
  endfunction

  function automatic void find_bracket(input int c[64], input int n, input int q,
                                       output int lo, output int hi);
    lo = 0;
    hi = n - 1;
    while (lo < n && c[lo] < q) lo++;
    lo--;
    if (lo < 0) lo = 0;
    while (hi >= 0 && c[hi] >= q) hi--;
    hi++;
    if (hi > n - 1) hi = n - 1;
    if (hi == lo) begin
      if (hi == 0) hi++;
      else if (hi == n - 1) lo--;
    end
  endfunction

  function automatic int points_used(logic [6:0] r);
    if (r == 0) return 1;
    if (r > 64) return 64;
    return int'(r);
  endfunction

  // Update the shadow grid, or queue the expected value of a query
  function automatic void grid_step(bgi_pkg::in_beat_t b);
    int                 nx, ny, xl, xh, yl, yh, f1, f2, res;
    bit                 sat, zero;
    longint             dx, dy;
    bgi_pkg::out_beat_t r;
    xl = 0; xh = 0; yl = 0; yh = 0; res = 0; sat = 0; zero = 0;
    case (bgi_pkg::op_e'(b.op))
      bgi_pkg::OP_LOAD_X: grid_x[b.index_x] = b.load_value;
      bgi_pkg::OP_LOAD_Y: grid_y[b.index_y] = b.load_value;
      bgi_pkg::OP_LOAD_F: grid_f[b.index_x * 64 + b.index_y] = b.load_value;
      default: begin
        nx = points_used(cnt_x);
        ny = points_used(cnt_y);
        if (nx > 1) find_bracket(grid_x, nx, b.query_x, xl, xh);
        if (ny > 1) find_bracket(grid_y, ny, b.query_y, yl, yh);
        if (nx > 1) begin
          dx = longint'(grid_x[xh]) - longint'(grid_x[xl]);
          if (dx == 0) begin
            zero = 1;
            f1 = 0;
            f2 = 0;
          end else begin
            f1 = lerp_q(grid_f[xl*64+yl], grid_f[xh*64+yl], dx,
                        longint'(b.query_x) - longint'(grid_x[xl]), sat);
            f2 = (ny > 1) ? lerp_q(grid_f[xl*64+yh], grid_f[xh*64+yh], dx,
                        longint'(b.query_x) - longint'(grid_x[xl]), sat) : f1;
          end
        end else begin
          f1 = grid_f[xl*64+yl];
          f2 = grid_f[xl*64+yh];
        end
        if (!zero) begin
          if (ny > 1) begin
            dy = longint'(grid_y[yh]) - longint'(grid_y[yl]);
            if (dy == 0) zero = 1;
            else res = lerp_q(f1, f2, dy, longint'(b.query_y) - longint'(grid_y[yl]), sat);
          end else begin
            res = f1;
          end
        end
        if (zero) begin
          r.result_value = '0;
          r.status = bgi_pkg::ST_ZERO;
        end else begin
          r.result_value = res;
          r.status = sat ? bgi_pkg::ST_SAT : bgi_pkg::ST_OK;
        end
        pending_results.push_back(r);
        n_queries++;
      end
    endcase
  endfunction

  // ---------------------------------------------------------------- result side
  int ready_mode = 0;
  int mode_cycles = 0;

  // Check each result beat, then pick the stall pattern for the next cycle
  always @(posedge clk) begin
    bgi_pkg::out_beat_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected: value %0d status %0d",
               out_data.result_value, out_data.status);
        n_errors++;
      end else begin
        want = pending_results.pop_front();
        n_checked++;
        if (want.status == bgi_pkg::ST_ZERO) n_zero++;
        if (want.status == bgi_pkg::ST_SAT) n_sat++;
        if (out_data.result_value !== want.result_value) begin
          $error("result_value: expected %0d, actual %0d",
                 want.result_value, out_data.result_value);
          n_errors++;
        end
        if (out_data.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_data.status);
          n_errors++;
        end
      end
    end
    if (mode_cycles == 0) begin
      ready_mode  = $urandom_range(0, 2);
      mode_cycles = $urandom_range(20, 300);
    end else begin
      mode_cycles--;
    end
    case (ready_mode)
      0:       out_ready <= 1'b1;
      1:       out_ready <= $urandom_range(0, 1);
      default: out_ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // ---------------------------------------------------------------- input side
  task automatic send_beat(input bgi_pkg::op_e op, input int ix, input int iy, input int lv,
                           input int qx, input int qy);
    bgi_pkg::in_beat_t b;
    int                gap;
    b.op = op;
    b.index_x = ix[5:0];
    b.index_y = iy[5:0];
    b.load_value = lv;
    b.query_x = qx;
    b.query_y = qy;
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    grid_step(b);
    n_beats++;
    // Bursts of random length, random gaps in between
    if (burst_left == 0) begin
      burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(30, 80) : $urandom_range(1, 12);
      gap = $urandom_range(1, 10);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end else begin
      burst_left--;
    end
  endtask

  task automatic load_x(int i, int v);
    send_beat(bgi_pkg::OP_LOAD_X, i, $urandom_range(0, 63), v, 0, 0);
  endtask
  task automatic load_y(int i, int v);
    send_beat(bgi_pkg::OP_LOAD_Y, $urandom_range(0, 63), i, v, 0, 0);
  endtask
  task automatic load_f(int i, int j, int v);
    send_beat(bgi_pkg::OP_LOAD_F, i, j, v, 0, 0);
  endtask
  task automatic query(int qx, int qy);
    send_beat(bgi_pkg::OP_QUERY, $urandom_range(0, 63), $urandom_range(0, 63), $urandom(),
              qx, qy);
  endtask

  // Registers change only once every result is out and the block has settled
  task automatic set_points(logic [6:0] px, logic [6:0] py);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
    cfg_we <= 1'b1; cfg_idx <= bgi_pkg::CFG_POINTS_X; cfg_data <= px;
    @(posedge clk);
    cfg_idx <= bgi_pkg::CFG_POINTS_Y; cfg_data <= py;
    @(posedge clk);
    cfg_we <= 1'b0;
    cnt_x = px;
    cnt_y = py;
  endtask

  // Load non-decreasing coordinates and a full table for the points in use
  task automatic load_grid(int nx, int ny, bit wide_f);
    int c;
    c = $urandom_range(0, 1 << 21) - (1 << 20);
    for (int i = 0; i < nx; i++) begin
      load_x(i, c);
      c += ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 1 << 18);
    end
    c = $urandom_range(0, 1 << 21) - (1 << 20);
    for (int j = 0; j < ny; j++) begin
      load_y(j, c);
      c += ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 1 << 18);
    end
    for (int i = 0; i < nx; i++)
      for (int j = 0; j < ny; j++)
        load_f(i, j, wide_f ? int'($urandom()) : $urandom_range(0, 1 << 25) - (1 << 24));
  endtask

  function automatic int near_point(int c_lo, int c_hi);
    longint span;
    span = longint'(c_hi) - longint'(c_lo) + 64'sd65536;
    if ($urandom_range(0, 9) == 0) return int'($urandom());
    return int'(longint'(c_lo) - span / 4 + longint'($urandom()) % (span + span / 2));
  endfunction

  task automatic random_queries(int n);
    int nx, ny;
    nx = points_used(cnt_x);
    ny = points_used(cnt_y);
    repeat (n) begin
      if ($urandom_range(0, 9) == 0)
        send_beat(bgi_pkg::op_e'($urandom_range(0, 2)), $urandom_range(0, 63),
                  $urandom_range(0, 63), $urandom(), $urandom(), $urandom());
      else
        query(near_point(grid_x[0], grid_x[nx-1]), near_point(grid_y[0], grid_y[ny-1]));
    end
  endtask

  // ---------------------------------------------------------------- tests
  // Reset counts are one point per axis: every query returns the single table entry
  task automatic test_reset_counts();
    load_f(0, 0, 32'h7FFF_FFFF);
    query(32'h8000_0000, 32'h7FFF_FFFF);
    load_f(0, 0, 32'h8000_0000);
    query(0, 0);
  endtask

  // Two by two grid: inside, corners, extrapolation, saturation, zero spacing
  task automatic test_two_by_two();
    set_points(7'd2, 7'd2);
    load_x(0, 0);        load_x(1, 32'h0001_0000);
    load_y(0, 0);        load_y(1, 32'h0002_0000);
    load_f(0, 0, 0);     load_f(1, 0, 32'h0001_0000);
    load_f(0, 1, 32'h0002_0000); load_f(1, 1, -32'sh0001_0000);
    query(32'h0000_8000, 32'h0001_0000);
    query(0, 0);
    query(32'h0001_0000, 32'h0002_0000);
    query(-32'sh0003_0000, 32'h0005_0000);
    query(32'h7FFF_FFFF, 32'h8000_0000);
    load_f(1, 0, 32'h7FFF_FFFF); load_f(0, 0, 32'h8000_0000);
    query(32'h0000_4000, 0);
    query(32'h0004_0000, 32'h0000_1000);
    load_x(1, 0);
    query(32'h0000_8000, 32'h0001_0000);
    load_x(1, 32'h0001_0000); load_y(1, 0);
    query(32'h0000_8000, 32'h0001_0000);
  endtask

  // Out-of-range counts clamp; widest axis in use with a narrow other axis
  task automatic test_extreme_counts();
    set_points(7'd127, 7'd0);
    load_grid(64, 1, 1'b0);
    random_queries(15);
    set_points(7'd2, 7'd64);
    load_grid(2, 64, 1'b1);
    random_queries(15);
  endtask

  task automatic test_random_grids();
    int nx, ny;
    while (n_beats < NumItems) begin
      nx = $urandom_range(1, 6);
      ny = $urandom_range(1, 6);
      if ($urandom_range(0, 7) == 0) nx = $urandom_range(7, 20);
      set_points((nx == 1 && $urandom_range(0, 1)) ? 7'd0 : 7'(nx), 7'(ny));
      load_grid(nx, ny, $urandom_range(0, 5) == 0);
      random_queries($urandom_range(5, 25));
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_counts();
    test_two_by_two();
    test_extreme_counts();
    test_random_grids();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
    n_errors += pending_results.size();
    $display("Sent %0d beats, %0d queries; checked %0d results (%0d zero spacing, %0d saturated).",
             n_beats, n_queries, n_checked, n_zero, n_sat);
    if (n_errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20_000_000;
    $display("Timeout with %0d results outstanding.", pending_results.size());
    $display("Verification failed");
    $finish;
  end

endmodule

`default_nettype wire
